[hdl/tcr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the threshold crossfade router.
// Used by tcr_cfg, tcr_ctrl, tcr_dp and threshold_crossfade_router; no dependencies.
package tcr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;
	localparam int FRAC_W     = 17;
	localparam int CNT_W      = 20;
	localparam int DIV_STEPS  = 17;
	localparam int ITER_W     = $clog2(DIV_STEPS);

	localparam logic [FRAC_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic signed [15:0] FULL_VOLT = 16'sd32767;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TH_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TH_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TH_MOD_ON    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_BASE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FADE     = 3'd5;

	// route modes; code 7 behaves as off
	localparam logic [2:0] MODE_OFF       = 3'd0;
	localparam logic [2:0] MODE_GATE1     = 3'd1;
	localparam logic [2:0] MODE_GATE2     = 3'd2;
	localparam logic [2:0] MODE_GATE_BOTH = 3'd3;
	localparam logic [2:0] MODE_SIG1      = 3'd4;
	localparam logic [2:0] MODE_SIG2      = 3'd5;
	localparam logic [2:0] MODE_SIG_BOTH  = 3'd6;
	localparam logic [2:0] MODE_RSVD      = 3'd7;

	typedef struct packed {
		logic signed [15:0] cv_level;
		logic signed [15:0] threshold_mod;
		logic signed [15:0] signal_level;
		logic signed [19:0] fade_offset_samples;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] out1_level;
		logic signed [15:0] out2_level;
		logic [15:0]        light1_level;
		logic [15:0]        light2_level;
	} result_t;

	typedef struct packed {
		logic [2:0]         route_mode;
		logic signed [15:0] threshold_base;
		logic signed [15:0] threshold_gain;
		logic               threshold_mod_on;
		logic [18:0]        fade_base_samples;
		logic [18:0]        min_fade_samples;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic mul_thresh;
		logic decide;
		logic div_init;
		logic div_step;
		logic fade_end;
		logic mul_o1;
		logic mul_o2;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic off_mode;
		logic fade_active;
		logic held;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/tcr_cfg.sv]
`timescale 1ns / 1ps
// Configuration register bank for the threshold crossfade router.
// Depends on tcr_pkg.
module tcr_cfg
	import tcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.route_mode        <= MODE_OFF;
			cfg_q.threshold_base    <= 16'sd3277;
			cfg_q.threshold_gain    <= '0;
			cfg_q.threshold_mod_on  <= 1'b0;
			cfg_q.fade_base_samples <= 19'd48;
			cfg_q.min_fade_samples  <= 19'd49;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROUTE_MODE: cfg_q.route_mode        <= cfg_data[2:0];
				REG_TH_BASE:    cfg_q.threshold_base    <= cfg_data[15:0];
				REG_TH_GAIN:    cfg_q.threshold_gain    <= cfg_data[15:0];
				REG_TH_MOD_ON:  cfg_q.threshold_mod_on  <= cfg_data[0];
				REG_FADE_BASE:  cfg_q.fade_base_samples <= cfg_data[18:0];
				REG_MIN_FADE:   cfg_q.min_fade_samples  <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

endmodule

[hdl/tcr_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the threshold crossfade router: steps one frame through
// threshold, switch update, serial divide, mixing and output. Depends on tcr_pkg.
module tcr_ctrl
	import tcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     frame_valid,
	output logic     frame_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_THRESH,
		S_DECIDE,
		S_DIV_INIT,
		S_DIV,
		S_FADE_END,
		S_MUL1,
		S_MUL2,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [ITER_W-1:0]   iter_q;

	assign frame_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load_in    = (state_q == S_IDLE) && frame_valid;
		cmd.mul_thresh = (state_q == S_THRESH);
		cmd.decide     = (state_q == S_DECIDE);
		cmd.div_init   = (state_q == S_DIV_INIT);
		cmd.div_step   = (state_q == S_DIV);
		cmd.fade_end   = (state_q == S_FADE_END);
		cmd.mul_o1     = (state_q == S_MUL1);
		cmd.mul_o2     = (state_q == S_MUL2);
		cmd.emit       = (state_q == S_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (frame_valid) state_q <= S_THRESH;
				end
				S_THRESH: state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q <= stat.off_mode ? S_EMIT : S_DIV_INIT;
				end
				S_DIV_INIT: begin
					iter_q  <= ITER_W'(DIV_STEPS - 1);
					state_q <= stat.fade_active ? S_DIV : S_MUL1;
				end
				S_DIV: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) state_q <= S_FADE_END;
				end
				S_FADE_END: state_q <= stat.held ? S_EMIT : S_MUL1;
				S_MUL1:     state_q <= S_MUL2;
				S_MUL2:     state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/tcr_dp.sv]
`timescale 1ns / 1ps
// Datapath for the threshold crossfade router: input frame, shared multiplier,
// switch and fade state, restoring divider, output register. Depends on tcr_pkg.
module tcr_dp
	import tcr_pkg::*;
#(
	parameter int unsigned MAX_FADE_SAMPLES = 480000
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  frame_t   frame,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_FADE_SAMPLES);
	localparam logic signed [17:0] TH_MAX = 18'sd32767;
	localparam logic signed [17:0] TH_MIN = -18'sd32767;

	frame_t              frame_q;
	logic signed [35:0]  prod_q;
	logic signed [15:0]  o1_q;

	logic                sw_q;
	logic                active_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    length_q;
	logic [FRAC_W-1:0]   start_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                held_q;

	logic [CNT_W:0]      rem_q;
	logic [FRAC_W-1:0]   quo_q;
	logic                over_q;

	logic                out_valid_q;
	result_t             out_q;

	logic                off_mode;
	logic                gate_mode;
	logic signed [16:0]  p_shift;
	logic signed [17:0]  th_sum;
	logic signed [17:0]  th_cl;
	logic signed [17:0]  th;
	logic signed [17:0]  cv_ext;
	logic                now_high;
	logic signed [20:0]  len_sum;
	logic [CNT_W-1:0]    len_cl;
	logic                long_fade;
	logic [FRAC_W-1:0]   frac_sat;
	logic                div_ge;
	logic [CNT_W:0]      rem_sub;
	logic [FRAC_W:0]     f_sum;
	logic                held_now;
	logic [FRAC_W-1:0]   w1;
	logic [FRAC_W-1:0]   w2;
	logic signed [15:0]  mix_v;
	logic signed [17:0]  mul_a;
	logic signed [17:0]  mul_b;
	logic [CNT_W-1:0]    count_base;
	result_t             mix_res;

	assign off_mode  = (cfg.route_mode == MODE_OFF) || (cfg.route_mode == MODE_RSVD);
	assign gate_mode = (cfg.route_mode == MODE_GATE1) || (cfg.route_mode == MODE_GATE2) ||
	                   (cfg.route_mode == MODE_GATE_BOTH);

	// threshold: base plus floor(mod * gain / 32768), clamped when modulated
	assign p_shift = prod_q[31:15];
	assign th_sum  = {{2{cfg.threshold_base[15]}}, cfg.threshold_base} +
	                 {p_shift[16], p_shift};
	always_comb begin
		priority if (th_sum > TH_MAX) th_cl = TH_MAX;
		else if (th_sum < TH_MIN)     th_cl = TH_MIN;
		else                          th_cl = th_sum;
	end
	assign th       = cfg.threshold_mod_on ? th_cl :
	                  {{2{cfg.threshold_base[15]}}, cfg.threshold_base};
	assign cv_ext   = {{2{frame_q.cv_level[15]}}, frame_q.cv_level};
	assign now_high = (cv_ext >= th);

	// fade length clamped to 0..MAX
	assign len_sum = {2'b00, cfg.fade_base_samples} +
	                 {frame_q.fade_offset_samples[19], frame_q.fade_offset_samples};
	always_comb begin
		priority if (len_sum[20])                        len_cl = '0;
		else if (len_sum > $signed({1'b0, LEN_MAX}))      len_cl = LEN_MAX;
		else                                             len_cl = len_sum[CNT_W-1:0];
	end
	assign long_fade = (len_cl > {1'b0, cfg.min_fade_samples});
	assign frac_sat  = (frac_q > ONE_Q16) ? ONE_Q16 : frac_q;

	// one restoring step per cycle
	assign div_ge  = (rem_q >= {1'b0, length_q});
	assign rem_sub = div_ge ? (rem_q - {1'b0, length_q}) : rem_q;

	assign f_sum      = {1'b0, quo_q} + {1'b0, start_q};
	assign held_now   = over_q || (f_sum > {1'b0, ONE_Q16});
	assign count_base = held_now ? '0 : count_q;

	// weight of OUT1
	always_comb begin
		if (active_q) w1 = sw_q ? (ONE_Q16 - frac_q) : frac_q;
		else          w1 = sw_q ? '0 : ONE_Q16;
	end
	assign w2 = ONE_Q16 - w1;

	assign mix_v = gate_mode ? FULL_VOLT : frame_q.signal_level;
	always_comb begin
		if (cmd.mul_thresh) begin
			mul_a = {{2{frame_q.threshold_mod[15]}}, frame_q.threshold_mod};
			mul_b = {{2{cfg.threshold_gain[15]}}, cfg.threshold_gain};
		end else begin
			mul_a = {{2{mix_v[15]}}, mix_v};
			mul_b = {1'b0, (cmd.mul_o1 ? w1 : w2)};
		end
	end

	always_comb begin
		mix_res.out1_level   = '0;
		mix_res.out2_level   = '0;
		mix_res.light1_level = w1[16] ? 16'hFFFF : w1[15:0];
		mix_res.light2_level = w2[16] ? 16'hFFFF : w2[15:0];
		if ((cfg.route_mode == MODE_GATE1) || (cfg.route_mode == MODE_GATE_BOTH) ||
		    (cfg.route_mode == MODE_SIG1) || (cfg.route_mode == MODE_SIG_BOTH))
			mix_res.out1_level = o1_q;
		if ((cfg.route_mode == MODE_GATE2) || (cfg.route_mode == MODE_GATE_BOTH) ||
		    (cfg.route_mode == MODE_SIG2) || (cfg.route_mode == MODE_SIG_BOTH))
			mix_res.out2_level = prod_q[31:16];
		if (cfg.route_mode == MODE_GATE1) mix_res.light2_level = '0;
		if (cfg.route_mode == MODE_GATE2) mix_res.light1_level = '0;
	end

	assign stat.off_mode    = off_mode;
	assign stat.fade_active = active_q;
	assign stat.held        = held_now;
	assign stat.out_free    = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) frame_q <= frame;
		if (cmd.mul_thresh || cmd.mul_o1 || cmd.mul_o2) prod_q <= mul_a * mul_b;
		if (cmd.mul_o2) o1_q <= prod_q[31:16];
		if (cmd.div_init) begin
			rem_q  <= {1'b0, count_q};
			quo_q  <= '0;
			// quotient would not fit 17 bits: the fade is over anyway
			over_q <= (length_q == '0) || ({1'b0, count_q} >= {length_q, 1'b0});
		end else if (cmd.div_step) begin
			rem_q <= {rem_sub[CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], div_ge};
		end
	end

	// switch and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q     <= 1'b0;
			active_q <= 1'b0;
			count_q  <= '0;
			length_q <= '0;
			start_q  <= '0;
			frac_q   <= '0;
			held_q   <= 1'b0;
		end else begin
			if (cmd.load_in) held_q <= 1'b0;
			if (cmd.decide) begin
				if (off_mode) begin
					sw_q     <= 1'b0;
					active_q <= 1'b0;
					count_q  <= '0;
					length_q <= '0;
					start_q  <= '0;
					frac_q   <= '0;
				end else if (now_high != sw_q) begin
					sw_q    <= now_high;
					count_q <= '0;
					if (long_fade) begin
						// restart from the complement when already fading
						active_q <= 1'b1;
						start_q  <= active_q ? (ONE_Q16 - frac_sat) : '0;
						length_q <= len_cl;
					end else begin
						active_q <= 1'b0;
						start_q  <= '0;
						frac_q   <= '0;
					end
				end
			end
			if (cmd.fade_end) begin
				held_q <= held_now;
				if (held_now) begin
					active_q <= 1'b0;
					start_q  <= '0;
					frac_q   <= '0;
				end else begin
					frac_q <= f_sum[FRAC_W-1:0];
				end
				count_q <= (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
			end
		end
	end

	// output register doubles as the last-result hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (off_mode)     out_q <= '0;
				else if (!held_q) out_q <= mix_res;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/threshold_crossfade_router.sv]
`timescale 1ns / 1ps
// Threshold switch with linear crossfade between two outputs.
// Channels: frame (frame_valid / frame_stall / frame) carries one sample frame;
// result (result_valid / result_stall / result) returns one result per frame.
// cfg_valid / cfg_ready / cfg_index / cfg_data writes the register bank; ready
// is always high. Write registers only while no frame is in flight.
// Timing: a frame is taken only while the sequencer is idle. Off mode goes
// straight to output; outside a fade the result skips the divide, and during a
// fade the 17-step serial divide of the fade fraction runs before mixing. The
// next frame is taken in the cycle after its result is loaded.
// A result waiting under result_stall holds; the block accepts the next frame
// meanwhile and holds that frame's result until the output register frees.
// Reset (arst_n low) clears switch and fade state and the held result, and
// loads register defaults: off mode, threshold 3277, fade 48, minimum 49.
// Depends on tcr_pkg, tcr_cfg, tcr_ctrl and tcr_dp.
module threshold_crossfade_router
	import tcr_pkg::*;
#(
	parameter int unsigned MAX_FADE_SAMPLES = 480000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_stall,
	input  frame_t                frame,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	tcr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tcr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	tcr_dp #(
		.MAX_FADE_SAMPLES (MAX_FADE_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.frame        (frame),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
